// ===== sv/otte_pkg.sv =====
// ============================================================================
// otte_pkg: shared types and constants for the one-time ticket table
// Request and result payloads, the token that walks the cell chain, and
// the command broadcast from the controller to every cell.
// ============================================================================
package otte_pkg;

    localparam int KEY_MAX = 64;   // widest ticket key
    localparam int ID_MAX = 32;    // widest match or player identifier
    localparam int TIME_W = 48;
    localparam int IDX_W = 6;      // slot index, enough for the largest table
    localparam int CNT_W = 7;      // slot count, can hold the largest table size
    localparam int LIFE_W = 32;

    localparam int DEF_ROOM_CAPACITY = 24;
    localparam int DEF_KEY_BITS = 64;
    localparam int DEF_ID_BITS = 32;

    localparam int MIN_COUNT = 2;
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 32'd10000;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_CONSUME = 2'd1,
        REQ_PURGE = 2'd2
    } req_type_t;

    typedef enum logic [3:0] {
        RS_PENDING = 4'd0,
        RS_LOADED = 4'd1,
        RS_ALREADY = 4'd2,
        RS_BAD_COUNT = 4'd3,
        RS_DUPLICATE = 4'd4,
        RS_ACCEPTED = 4'd5,
        RS_USED = 4'd6,
        RS_NOT_FOUND = 4'd7,
        RS_EXPIRED = 4'd8,
        RS_MISMATCH = 4'd9,
        RS_PURGED = 4'd10,
        RS_NONE_PURGED = 4'd11
    } res_status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_LIVE = 2'd1,
        SLOT_USED = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_CONS = 2'd1,
        MODE_DUP = 2'd2,
        MODE_MIN = 2'd3
    } tok_mode_t;

    typedef enum logic [2:0] {
        CMD_NOP = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_COMMIT = 3'd2,
        CMD_ERASE = 3'd3,
        CMD_USE = 3'd4,
        CMD_MARK = 3'd5,
        CMD_UNPEND = 3'd6
    } cmd_op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CONS = 2'd1,
        S_DUP = 2'd2,
        S_MIN = 2'd3
    } state_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [KEY_MAX-1:0] ticket;
        logic [ID_MAX-1:0] match_id;
        logic [ID_MAX-1:0] player_id;
        logic [TIME_W-1:0] now;
        logic last;
    } req_t;

    typedef struct packed {
        res_status_t status;
        logic [ID_MAX-1:0] purged_player;
        logic end_of_run;
    } result_t;

    typedef struct packed {
        tok_mode_t mode;
        logic [KEY_MAX-1:0] key;
        logic [ID_MAX-1:0] match;
        logic [ID_MAX-1:0] player;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] lim;
        logic hit;
        logic used_hit;
        logic dup;
        logic cap;
    } tok_t;

    typedef struct packed {
        cmd_op_t op;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic [KEY_MAX-1:0] key;
        logic [ID_MAX-1:0] match;
        logic [ID_MAX-1:0] player;
    } cmd_t;

endpackage

// ===== sv/otte_cell.sv =====
// ============================================================================
// otte_cell: one slot of the ticket table
// Holds one entry and updates the token passing through it, one register
// per cell, so the token is registered at each slot as it crosses the chain.
// ============================================================================
module otte_cell #(
    parameter int INDEX = 0,
    parameter int KEY_BITS = otte_pkg::DEF_KEY_BITS,
    parameter int ID_BITS = otte_pkg::DEF_ID_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  otte_pkg::cmd_t   cmd,
    input  otte_pkg::tok_t   tin,
    output otte_pkg::tok_t   tout
);

    logic [KEY_BITS-1:0] key_reg;
    logic [ID_BITS-1:0] match_reg;
    logic [ID_BITS-1:0] player_reg;
    otte_pkg::slot_state_t status_reg;
    otte_pkg::slot_state_t status_next;
    logic pend_reg;
    logic pend_next;
    otte_pkg::tok_t tok_reg;
    otte_pkg::tok_t tok_next;

    logic is_me;
    logic below_n;
    logic [otte_pkg::IDX_W-1:0] my_idx;
    logic [otte_pkg::KEY_MAX-1:0] my_key;
    logic [otte_pkg::ID_MAX-1:0] my_match;
    logic [otte_pkg::ID_MAX-1:0] my_player;

    assign my_idx = otte_pkg::IDX_W'(INDEX);
    assign is_me = (cmd.idx == my_idx);
    assign below_n = (otte_pkg::CNT_W'(INDEX) < cmd.count);
    assign my_key = otte_pkg::KEY_MAX'(key_reg);
    assign my_match = otte_pkg::ID_MAX'(match_reg);
    assign my_player = otte_pkg::ID_MAX'(player_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.op == otte_pkg::CMD_WRITE && is_me)
        begin
            key_reg <= cmd.key[KEY_BITS-1:0];
            match_reg <= cmd.match[ID_BITS-1:0];
            player_reg <= cmd.player[ID_BITS-1:0];
        end
    end

    always_comb
    begin
        status_next = status_reg;
        pend_next = pend_reg;
        case (cmd.op)
            otte_pkg::CMD_COMMIT:
            begin
                if (below_n)
                    status_next = otte_pkg::SLOT_LIVE;
            end
            otte_pkg::CMD_ERASE:
            begin
                if (is_me)
                    status_next = otte_pkg::SLOT_EMPTY;
            end
            otte_pkg::CMD_USE:
            begin
                if (is_me)
                    status_next = otte_pkg::SLOT_USED;
            end
            otte_pkg::CMD_MARK:
            begin
                // Expired live entries are erased at once and queued for reporting.
                if (status_reg == otte_pkg::SLOT_LIVE)
                begin
                    status_next = otte_pkg::SLOT_EMPTY;
                    pend_next = 1'b1;
                end
            end
            otte_pkg::CMD_UNPEND:
            begin
                if (is_me)
                    pend_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        tok_next = tin;
        case (tin.mode)
            otte_pkg::MODE_CONS:
            begin
                if (status_reg == otte_pkg::SLOT_USED && my_key == tin.key)
                    tok_next.used_hit = 1'b1;
                if (status_reg == otte_pkg::SLOT_LIVE && my_key == tin.key && !tin.hit)
                begin
                    tok_next.hit = 1'b1;
                    tok_next.idx = my_idx;
                    tok_next.match = my_match;
                    tok_next.player = my_player;
                end
            end
            otte_pkg::MODE_DUP:
            begin
                // The probe slot loads its entry; later slots of the set compare.
                if (my_idx == tin.idx)
                begin
                    tok_next.cap = 1'b1;
                    tok_next.key = my_key;
                    tok_next.player = my_player;
                end
                else if (tin.cap && otte_pkg::CNT_W'(INDEX) < tin.lim
                         && (my_key == tin.key || my_player == tin.player))
                begin
                    tok_next.dup = 1'b1;
                end
            end
            otte_pkg::MODE_MIN:
            begin
                if (pend_reg && (!tin.hit || my_player < tin.player))
                begin
                    tok_next.hit = 1'b1;
                    tok_next.idx = my_idx;
                    tok_next.player = my_player;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= otte_pkg::SLOT_EMPTY;
            pend_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            status_reg <= status_next;
            pend_reg <= pend_next;
            tok_reg <= tok_next;
        end
    end

    assign tout = tok_reg;

endmodule

// ===== sv/one_time_ticket_table_with_expiry.sv =====
// ============================================================================
// one_time_ticket_table_with_expiry: one-shot admission ticket table
// Loads a set of participants once, then checks tickets against it and
// purges expired entries in ascending player order.
// ============================================================================
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+--------------------------
//  request  | start, busy (transfer: start&!busy) | req (otte_pkg::req_t)
//  result   | result_valid, high for one cycle  | result (otte_pkg::result_t)
//  config   | APB psel/penable/pwrite, pready=1 | lifetime_ms at address 0
//
// A non-last load or an unknown request is answered without leaving idle. A
// consume sends one token down the chain of ROOM_CAPACITY cells. The closing
// load of an n-entry set makes one chain pass per probe slot; a purge of k
// entries takes (k+1) passes.
// Reset clears the slot states, the load flags and sets lifetime to 10000.
// Results cannot be stalled; each is shown for exactly one cycle.
module one_time_ticket_table_with_expiry #(
    parameter int ROOM_CAPACITY = otte_pkg::DEF_ROOM_CAPACITY,
    parameter int KEY_BITS = otte_pkg::DEF_KEY_BITS,
    parameter int ID_BITS = otte_pkg::DEF_ID_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  otte_pkg::req_t    req,
    output logic              result_valid,
    output otte_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDXW = $clog2(ROOM_CAPACITY);
    localparam int CNTW = $clog2(ROOM_CAPACITY + 1);

    otte_pkg::state_t state_reg;
    otte_pkg::state_t state_next;
    otte_pkg::req_t req_reg;
    otte_pkg::req_t req_next;
    logic expired_reg;
    logic expired_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic ovf_reg;
    logic ovf_next;
    logic loaded_reg;
    logic loaded_next;
    logic [otte_pkg::TIME_W-1:0] expiry_reg;
    logic [otte_pkg::TIME_W-1:0] expiry_next;
    logic [otte_pkg::LIFE_W-1:0] lifetime_reg;
    logic [IDXW-1:0] probe_reg;
    logic [IDXW-1:0] probe_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic prev_valid_reg;
    logic prev_valid_next;
    logic [ID_BITS-1:0] prev_player_reg;
    logic [ID_BITS-1:0] prev_player_next;
    logic res_valid_reg;
    logic res_valid_next;
    otte_pkg::result_t res_reg;
    otte_pkg::result_t res_next;

    otte_pkg::cmd_t cmd;
    otte_pkg::tok_t chain [0:ROOM_CAPACITY];
    otte_pkg::tok_t tail;

    logic accept;
    logic scan_done;
    logic [CNTW-1:0] staged_n;
    logic staged_ovf;
    logic load_bad;
    logic load_go;
    logic req_expired;
    logic [otte_pkg::KEY_MAX-1:0] in_key;
    logic [otte_pkg::ID_MAX-1:0] in_match;
    logic [otte_pkg::ID_MAX-1:0] in_player;
    logic [otte_pkg::KEY_MAX-1:0] reg_key;
    logic [otte_pkg::ID_MAX-1:0] reg_match;
    logic [otte_pkg::ID_MAX-1:0] reg_player;
    logic [otte_pkg::TIME_W:0] expiry_sum;

    assign accept = start && (state_reg == otte_pkg::S_IDLE);
    assign scan_done = (cnt_reg == CNTW'(ROOM_CAPACITY));
    assign tail = chain[ROOM_CAPACITY];
    assign req_expired = (req.now >= expiry_reg);

    assign in_key = otte_pkg::KEY_MAX'(req.ticket[KEY_BITS-1:0]);
    assign in_match = otte_pkg::ID_MAX'(req.match_id[ID_BITS-1:0]);
    assign in_player = otte_pkg::ID_MAX'(req.player_id[ID_BITS-1:0]);
    assign reg_key = otte_pkg::KEY_MAX'(req_reg.ticket[KEY_BITS-1:0]);
    assign reg_match = otte_pkg::ID_MAX'(req_reg.match_id[ID_BITS-1:0]);
    assign reg_player = otte_pkg::ID_MAX'(req_reg.player_id[ID_BITS-1:0]);
    assign expiry_sum = {1'b0, req_reg.now} + (otte_pkg::TIME_W + 1)'(lifetime_reg);

    // Staging outcome of a load item, shared by both FSM blocks.
    always_comb
    begin
        staged_n = count_reg;
        staged_ovf = ovf_reg;
        if (!loaded_reg)
        begin
            if (count_reg < CNTW'(ROOM_CAPACITY))
                staged_n = count_reg + CNTW'(1);
            else
                staged_ovf = 1'b1;
        end
        load_bad = staged_ovf || (staged_n < CNTW'(otte_pkg::MIN_COUNT))
                   || (lifetime_reg == '0);
        load_go = req.last && !loaded_reg && !load_bad;
    end

    // Head of the chain: a fresh token whose mode follows the state.
    always_comb
    begin
        chain[0] = '0;
        case (state_reg)
            otte_pkg::S_CONS:
            begin
                chain[0].mode = otte_pkg::MODE_CONS;
                chain[0].key = reg_key;
            end
            otte_pkg::S_DUP:
            begin
                chain[0].mode = otte_pkg::MODE_DUP;
                chain[0].idx = otte_pkg::IDX_W'(probe_reg);
                chain[0].lim = otte_pkg::CNT_W'(count_reg);
            end
            otte_pkg::S_MIN:
            begin
                chain[0].mode = otte_pkg::MODE_MIN;
            end
            default:
            begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < ROOM_CAPACITY; gi++)
        begin : g_cell
            otte_cell #(
                .INDEX(gi),
                .KEY_BITS(KEY_BITS),
                .ID_BITS(ID_BITS)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .cmd(cmd),
                .tin(chain[gi]),
                .tout(chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            otte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        otte_pkg::REQ_LOAD:
                        begin
                            if (load_go)
                                state_next = otte_pkg::S_DUP;
                        end
                        otte_pkg::REQ_CONSUME:
                            state_next = otte_pkg::S_CONS;
                        otte_pkg::REQ_PURGE:
                            state_next = otte_pkg::S_MIN;
                        default:
                            state_next = otte_pkg::S_IDLE;
                    endcase
                end
            end
            otte_pkg::S_CONS:
            begin
                if (scan_done)
                    state_next = otte_pkg::S_IDLE;
            end
            otte_pkg::S_DUP:
            begin
                if (scan_done && (tail.dup
                    || CNTW'(probe_reg) == count_reg - CNTW'(otte_pkg::MIN_COUNT)))
                    state_next = otte_pkg::S_IDLE;
            end
            otte_pkg::S_MIN:
            begin
                if (scan_done && !tail.hit)
                    state_next = otte_pkg::S_IDLE;
            end
            default:
                state_next = otte_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        res_valid_next = 1'b0;
        res_next = '0;
        res_next.end_of_run = 1'b1;
        req_next = req_reg;
        expired_next = expired_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        loaded_next = loaded_reg;
        expiry_next = expiry_reg;
        probe_next = probe_reg;
        cnt_next = cnt_reg + CNTW'(1);
        prev_valid_next = prev_valid_reg;
        prev_player_next = prev_player_reg;
        case (state_reg)
            otte_pkg::S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    req_next = req;
                    expired_next = req_expired;
                    case (req.req_type)
                        otte_pkg::REQ_LOAD:
                        begin
                            if (!loaded_reg && count_reg < CNTW'(ROOM_CAPACITY))
                            begin
                                cmd.op = otte_pkg::CMD_WRITE;
                                cmd.idx = otte_pkg::IDX_W'(count_reg);
                                cmd.key = in_key;
                                cmd.match = in_match;
                                cmd.player = in_player;
                            end
                            if (!req.last)
                            begin
                                count_next = staged_n;
                                ovf_next = staged_ovf;
                                res_valid_next = 1'b1;
                                res_next.status = otte_pkg::RS_PENDING;
                            end
                            else if (loaded_reg)
                            begin
                                count_next = '0;
                                ovf_next = 1'b0;
                                res_valid_next = 1'b1;
                                res_next.status = otte_pkg::RS_ALREADY;
                            end
                            else if (load_bad)
                            begin
                                count_next = '0;
                                ovf_next = 1'b0;
                                res_valid_next = 1'b1;
                                res_next.status = otte_pkg::RS_BAD_COUNT;
                            end
                            else
                            begin
                                count_next = staged_n;
                                probe_next = '0;
                            end
                        end
                        otte_pkg::REQ_CONSUME:
                        begin
                        end
                        otte_pkg::REQ_PURGE:
                        begin
                            prev_valid_next = 1'b0;
                            if (req_expired)
                                cmd.op = otte_pkg::CMD_MARK;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            res_next.status = otte_pkg::RS_NOT_FOUND;
                        end
                    endcase
                end
            end
            otte_pkg::S_CONS:
            begin
                if (scan_done)
                begin
                    res_valid_next = 1'b1;
                    cmd.idx = tail.idx;
                    if (tail.used_hit)
                        res_next.status = otte_pkg::RS_USED;
                    else if (!tail.hit)
                        res_next.status = otte_pkg::RS_NOT_FOUND;
                    else if (expired_reg)
                    begin
                        cmd.op = otte_pkg::CMD_ERASE;
                        res_next.status = otte_pkg::RS_EXPIRED;
                    end
                    else if (tail.match != reg_match || tail.player != reg_player)
                        res_next.status = otte_pkg::RS_MISMATCH;
                    else
                    begin
                        cmd.op = otte_pkg::CMD_USE;
                        res_next.status = otte_pkg::RS_ACCEPTED;
                    end
                end
            end
            otte_pkg::S_DUP:
            begin
                if (scan_done)
                begin
                    cnt_next = '0;
                    if (tail.dup)
                    begin
                        count_next = '0;
                        ovf_next = 1'b0;
                        res_valid_next = 1'b1;
                        res_next.status = otte_pkg::RS_DUPLICATE;
                    end
                    else if (CNTW'(probe_reg) == count_reg - CNTW'(otte_pkg::MIN_COUNT))
                    begin
                        cmd.op = otte_pkg::CMD_COMMIT;
                        cmd.count = otte_pkg::CNT_W'(count_reg);
                        loaded_next = 1'b1;
                        expiry_next = expiry_sum[otte_pkg::TIME_W]
                                      ? '1 : expiry_sum[otte_pkg::TIME_W-1:0];
                        count_next = '0;
                        ovf_next = 1'b0;
                        res_valid_next = 1'b1;
                        res_next.status = otte_pkg::RS_LOADED;
                    end
                    else
                        probe_next = probe_reg + IDXW'(1);
                end
            end
            otte_pkg::S_MIN:
            begin
                if (scan_done)
                begin
                    cnt_next = '0;
                    // Each result is sent one pass late, once it is known whether
                    // another player follows it.
                    res_next.status = otte_pkg::RS_PURGED;
                    res_next.purged_player = otte_pkg::ID_MAX'(prev_player_reg);
                    if (tail.hit)
                    begin
                        cmd.op = otte_pkg::CMD_UNPEND;
                        cmd.idx = tail.idx;
                        res_valid_next = prev_valid_reg;
                        res_next.end_of_run = 1'b0;
                        prev_valid_next = 1'b1;
                        prev_player_next = tail.player[ID_BITS-1:0];
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        if (!prev_valid_reg)
                        begin
                            res_next.status = otte_pkg::RS_NONE_PURGED;
                            res_next.purged_player = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        expired_reg <= expired_next;
        probe_reg <= probe_next;
        prev_player_reg <= prev_player_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= otte_pkg::S_IDLE;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            loaded_reg <= 1'b0;
            expiry_reg <= '0;
            cnt_reg <= '0;
            prev_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            loaded_reg <= loaded_next;
            expiry_reg <= expiry_next;
            cnt_reg <= cnt_next;
            prev_valid_reg <= prev_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lifetime_reg <= otte_pkg::LIFETIME_RESET;
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
            lifetime_reg <= pwdata;
    end

    assign prdata = (paddr[2] == 1'b0) ? lifetime_reg : '0;
    assign pready = 1'b1;
    assign busy = (state_reg != otte_pkg::S_IDLE);
    assign result_valid = res_valid_reg;
    assign result = res_reg;

    a_player_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != otte_pkg::RS_PURGED |-> result.purged_player == '0)
        else $error("purged_player set on a result that is not a purge report");

    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == otte_pkg::REQ_LOAD && !req.last
        |=> result_valid && result.status == otte_pkg::RS_PENDING && !busy)
        else $error("non-last load did not answer pending in one cycle");

    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(loaded_reg) |-> result_valid && result.status == otte_pkg::RS_LOADED)
        else $error("table committed without a loaded result");

    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.end_of_run |-> busy && state_reg == otte_pkg::S_MIN)
        else $error("open run outside a purge");

endmodule
